// ===== rtl/ride_slot_log_manager_unit_macros.svh =====
// assertion macros for the ride slot log manager
`ifndef RIDE_SLOT_LOG_MANAGER_UNIT_MACROS_SVH
`define RIDE_SLOT_LOG_MANAGER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define RSLM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rslm check failed");
// implication checked in the cycle after the antecedent
`define RSLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rslm check failed");
`endif

// ===== rtl/rslm_pkg.sv =====
// ----------------------------------------------------------------------------
// rslm_pkg
// shared types and constants of the ride slot log manager
// ----------------------------------------------------------------------------
package rslm_pkg;
   localparam int unsigned NUM_SLOTS_DEF    = 5;
   localparam int unsigned SLOT_BYTES_DEF   = 2097152;
   localparam int unsigned SECTOR_BYTES_DEF = 4096;

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_APPEND = 3'd1,
      OP_STOP   = 3'd2,
      OP_EXPORT = 3'd3,
      OP_TOTALS = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ACTIVE     = 3'd1,
      ST_NO_FREE    = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_ACTIVE = 3'd4,
      ST_NOT_PEND   = 3'd5,
      ST_NO_TOTALS  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_FREE = 2'd0,
      PH_REC  = 2'd1,
      PH_PEND = 2'd2
   } phase_type;

   localparam logic [1:0] CSR_BASE   = 2'd0;
   localparam logic [1:0] CSR_EXTRA  = 2'd1;
   localparam logic [1:0] CSR_RECORD = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] timestamp;
      logic [15:0] distance_delta;
      logic [15:0] ascent_delta;
      logic [2:0]  slot_id;
      logic        export_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic        erase_first;
      logic [25:0] flash_addr;
      logic [1:0]  pad_count;
      logic [9:0]  write_len;
      logic [21:0] stream_len;
      logic [21:0] record_count;
      logic [31:0] ride_begin;
      logic [31:0] last_time;
      logic [31:0] distance_total;
      logic [31:0] climb_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] data;
   } csr_type;

   // one slot's record as kept in the slot memory
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] last;
      logic [21:0] cursor;
      logic [21:0] records;
      logic [31:0] distance;
      logic [31:0] climb;
   } entry_type;
endpackage

// ===== rtl/rslm_if.sv =====
// ----------------------------------------------------------------------------
// rslm_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rslm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ride_slot_log_manager_unit.sv =====
// ----------------------------------------------------------------------------
// ride_slot_log_manager_unit
// flash log slot table: start, append planning, stop, export and totals
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | opcode, timestamp, deltas, slot id, export flag
// rsp     | out | status, slot, write plan, slot counters and totals
// csr     | in  | register index and write data
//
// a request is taken in idle; its response is valid after the scan state
// S_SCAN, the memory read state S_READ and the compute and write-back state
// S_CALC. only start and totals with no live ride stay on in S_SCAN: they
// scan the phase/record flags one slot a cycle up to the first hit or the
// last slot. one request in flight at a time; the result register holds
// the response while rsp is stalled, and the next request is taken at the
// earliest in the cycle after the response is accepted.
// reset clears phases, hint and active ride; memory entries of a free slot
// are rewritten on start, so the memory itself needs no clearing pass.
module ride_slot_log_manager_unit
   import rslm_pkg::*;
#(
   parameter int unsigned NUM_SLOTS    = NUM_SLOTS_DEF,
   parameter int unsigned SLOT_BYTES   = SLOT_BYTES_DEF,
   parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input logic     clock,
   input logic     reset,
   rslm_if.sink    req,
   rslm_if.source  rsp,
   rslm_if.sink    csr
);
   localparam int SW = 3;
   localparam int SECW = $clog2(SECTOR_BYTES);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_READ  = 5'b00100,
      S_CALC  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;

   // configuration registers
   logic [25:0] base_ff;
   logic [7:0]  extra_ff, recb_ff;

   // per slot control flags (small, flops)
   logic [1:0]  phase_ff [NUM_SLOTS];
   logic        hasrec_ff [NUM_SLOTS];
   logic [SW-1:0] hint_ff, active_idx_ff, sel_ff, scan_n_ff;
   logic        active_ff;
   logic        found_ff;

   // slot memory
   entry_type mem [NUM_SLOTS];
   entry_type rd_ff;
   logic      we;
   entry_type wd;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   wire req_fire = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         extra_ff <= '0;
         recb_ff  <= 8'd1;
      end else if (csr.valid) begin
         case (csr.data.index)
            CSR_BASE:   base_ff  <= csr.data.data[25:0];
            CSR_EXTRA:  extra_ff <= csr.data.data[7:0];
            CSR_RECORD: recb_ff  <= csr.data.data[7:0];
            default: ;
         endcase
      end
   end

   // scan slot = (hint + n) mod NUM_SLOTS for start, n for totals
   logic [SW:0] scan_sum;
   logic [SW-1:0] scan_slot;
   logic          scan_on, scan_hit;
   always_comb begin
      scan_sum = {1'b0, hint_ff} + {1'b0, scan_n_ff};
      if (req_ff.opcode == OP_START) begin
         scan_slot = (scan_sum >= (SW+1)'(NUM_SLOTS)) ?
                     SW'(scan_sum - (SW+1)'(NUM_SLOTS)) : scan_sum[SW-1:0];
      end else begin
         scan_slot = scan_n_ff;
      end
      // only start and totals without a live ride walk the flags
      scan_on = ((req_ff.opcode == OP_START) || (req_ff.opcode == OP_TOTALS)) && !active_ff;
      scan_hit = ((req_ff.opcode == OP_START) && (phase_ff[scan_slot] == PH_FREE)) ||
                 ((req_ff.opcode == OP_TOTALS) && hasrec_ff[scan_slot]);
   end

   // memory read, registered
   always_ff @(posedge clock) begin
      rd_ff <= mem[sel_ff];
      if (we) mem[sel_ff] <= wd;
   end

   // append planning from the registered entry
   logic [8:0]  len;
   logic [22:0] cur, cur_end;
   logic [SECW:0] off_sum;
   logic [25:0] addr;
   logic [1:0]  lead;
   logic [9:0]  wlen;
   logic        full, erase;
   logic [32:0] dsum, csum;
   always_comb begin
      // extra header bytes only ahead of the ride's first record
      len = {1'b0, recb_ff} + ((rd_ff.records == '0) ? {1'b0, extra_ff} : 9'd0);
      off_sum = {1'b0, rd_ff.cursor[SECW-1:0]} + (SECW+1)'(len);
      cur = {1'b0, rd_ff.cursor};
      if (off_sum > (SECW+1)'(SECTOR_BYTES))
         cur = {cur[22:SECW] + 1'b1, {SECW{1'b0}}};
      cur_end = cur + 23'(len);
      full = ({1'b0, cur_end} > 24'(SLOT_BYTES));
      erase = (cur[SECW-1:0] == '0);
      lead = cur[1:0];
      wlen = 10'((11'(lead) + 11'(len) + 11'd3) & ~11'd3);
      addr = 26'(base_ff + 26'(sel_ff) * 26'(SLOT_BYTES) + {cur[25-3:2], 2'b00});
      dsum = {1'b0, rd_ff.distance} + 33'(req_ff.distance_delta);
      csum = {1'b0, rd_ff.climb} + 33'(req_ff.ascent_delta);
   end

   entry_type zero_e;
   assign zero_e = '0;

   function automatic rsp_type fill(input status_type st, input logic [2:0] s,
                                    input entry_type e);
      rsp_type r;
      r = '0;
      r.status = st;
      r.slot = s;
      r.stream_len = e.cursor;
      r.record_count = e.records;
      r.ride_begin = e.start;
      r.last_time = e.last;
      r.distance_total = e.distance;
      r.climb_total = e.climb;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      we = 1'b0;
      wd = rd_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_SCAN;
         S_SCAN:  if (!scan_on || scan_hit || (scan_n_ff == SW'(NUM_SLOTS - 1)))
                     state_in = S_READ;
         S_READ:  state_in = S_CALC;
         S_CALC:  state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_CALC) begin
         case (req_ff.opcode)
            OP_START: if (found_ff) begin
               we = 1'b1;
               wd = '0;
               wd.start = req_ff.timestamp;
               wd.last = req_ff.timestamp;
            end
            OP_APPEND: if (active_ff && !full) begin
               we = 1'b1;
               wd.cursor = cur_end[21:0];
               if (rd_ff.records != '1) wd.records = rd_ff.records + 1'b1;
               wd.last = req_ff.timestamp;
               wd.distance = dsum[32] ? '1 : dsum[31:0];
               wd.climb = csum[32] ? '1 : csum[31:0];
            end
            OP_EXPORT: if (found_ff && req_ff.export_ok) begin
               we = 1'b1;
               wd = '0;
            end
            default: ;
         endcase
      end
   end

   // response built from the read entry or the write-back value
   always_comb begin
      rsp_in = '0;
      case (req_ff.opcode)
         OP_START:
            if (active_ff) rsp_in = fill(ST_ACTIVE, active_idx_ff, zero_e);
            else if (found_ff) rsp_in = fill(ST_OK, sel_ff, wd);
            else rsp_in = fill(ST_NO_FREE, '0, zero_e);
         OP_APPEND:
            if (!active_ff) rsp_in = fill(ST_NOT_ACTIVE, '0, zero_e);
            else if (full) rsp_in = fill(ST_FULL, sel_ff, rd_ff);
            else begin
               rsp_in = fill(ST_OK, sel_ff, wd);
               rsp_in.erase_first = erase;
               rsp_in.flash_addr = addr;
               rsp_in.pad_count = lead;
               rsp_in.write_len = wlen;
            end
         OP_STOP:
            if (!active_ff) rsp_in = fill(ST_NOT_ACTIVE, '0, zero_e);
            else rsp_in = fill(ST_OK, sel_ff, rd_ff);
         OP_EXPORT:
            if (!found_ff) rsp_in = fill(ST_NOT_PEND, req_ff.slot_id, zero_e);
            else rsp_in = fill(ST_OK, sel_ff, wd);
         OP_TOTALS:
            if (active_ff) rsp_in = fill(ST_OK, active_idx_ff, rd_ff);
            else if (found_ff) rsp_in = fill(ST_OK, sel_ff, rd_ff);
            else rsp_in = fill(ST_NO_TOTALS, '0, zero_e);
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hint_ff <= '0;
         active_ff <= 1'b0;
         active_idx_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            phase_ff[i] <= PH_FREE;
            hasrec_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_CALC) begin
            case (req_ff.opcode)
               OP_START: if (found_ff && !active_ff) begin
                  phase_ff[sel_ff] <= PH_REC;
                  hasrec_ff[sel_ff] <= 1'b0;
                  hint_ff <= (sel_ff == SW'(NUM_SLOTS - 1)) ? '0 : sel_ff + 1'b1;
                  active_ff <= 1'b1;
                  active_idx_ff <= sel_ff;
               end
               OP_APPEND: if (active_ff) begin
                  if (full) begin
                     phase_ff[sel_ff] <= PH_PEND;
                     active_ff <= 1'b0;
                  end else hasrec_ff[sel_ff] <= 1'b1;
               end
               OP_STOP: if (active_ff) begin
                  phase_ff[sel_ff] <= PH_PEND;
                  active_ff <= 1'b0;
               end
               OP_EXPORT: if (found_ff && req_ff.export_ok) begin
                  phase_ff[sel_ff] <= PH_FREE;
                  hasrec_ff[sel_ff] <= 1'b0;
               end
               default: ;
            endcase
            rsp_valid_ff <= (req_ff.opcode inside {OP_START, OP_APPEND, OP_STOP,
                                                   OP_EXPORT, OP_TOTALS});
         end
      end
   end

   // scan sequencer and response register
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (req_fire) begin
            req_ff <= req.data;
            scan_n_ff <= '0;
            if (req.data.opcode == OP_EXPORT) begin
               sel_ff <= req.data.slot_id;
               found_ff <= ({1'b0, req.data.slot_id} < (SW+1)'(NUM_SLOTS)) &&
                           (phase_ff[req.data.slot_id] == PH_PEND);
            end else begin
               sel_ff <= active_idx_ff;
               found_ff <= 1'b0;
            end
         end
         S_SCAN: begin
            // walk the flags one slot per cycle, stop at the first hit
            scan_n_ff <= scan_n_ff + 1'b1;
            if (scan_on && scan_hit) begin
               found_ff <= 1'b1;
               sel_ff <= scan_slot;
            end
         end
         S_CALC: rsp_ff <= rsp_in;
         default: ;
      endcase
   end
endmodule

// ===== rtl/rslm_checker.sv =====
// ----------------------------------------------------------------------------
// rslm_checker
// port level checks of the ride slot log manager
// ----------------------------------------------------------------------------
`include "ride_slot_log_manager_unit_macros.svh"
module rslm_checker
   import rslm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);
   // no new request while a response waits
   `RSLM_ASSERT_IMPL(a_no_req_with_rsp, clock, reset, rsp_valid, !req_ready)
   // a held response keeps its payload
   `RSLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // error results carry no write plan
   `RSLM_ASSERT_IMPL(a_err_no_plan, clock, reset, rsp_valid && rsp_data.status != ST_OK,
      !rsp_data.erase_first && rsp_data.write_len == '0)
   // an accepted request blocks a new one in the cycle after
   `RSLM_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind ride_slot_log_manager_unit rslm_checker u_rslm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ride slot log manager: a directed table, a
// long single-slot ride and random ride traffic under varied idling and
// settings, every response compared with an in-bench slot table predictor
// ----------------------------------------------------------------------------
module tb;
   import rslm_pkg::*;

   localparam int unsigned SLOTS  = NUM_SLOTS_DEF;
   localparam int unsigned SLOTSZ = SLOT_BYTES_DEF;
   localparam int unsigned SECTSZ = SECTOR_BYTES_DEF;
   localparam int unsigned REC_MAX = 22'h3FFFFF;

   logic clock;
   logic reset;

   rslm_if #(.payload_type(req_type)) req_ch ();
   rslm_if #(.payload_type(rsp_type)) rsp_ch ();
   rslm_if #(.payload_type(csr_type)) csr_ch ();

   ride_slot_log_manager_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5 clock = ~clock;

   // ---------------- predicted slot table ----------------
   phase_type   pr_phase[SLOTS];
   logic [31:0] pr_start[SLOTS];
   logic [31:0] pr_last[SLOTS];
   int unsigned pr_cursor[SLOTS];
   int unsigned pr_recs[SLOTS];
   logic [31:0] pr_dist[SLOTS];
   logic [31:0] pr_climb[SLOTS];
   int unsigned pr_hint;
   bit          pr_live;
   int unsigned pr_live_idx;
   logic [25:0] reg_base;
   logic [7:0]  reg_extra;
   logic [7:0]  reg_rec;

   rsp_type expected_rsps[$];
   int          fail_count;
   int          idle_pct;
   int          stall_pct;
   int          hold_len;
   int          hold_left;

   function automatic void wipe_slot(int unsigned i);
      pr_phase[i]  = PH_FREE;
      pr_start[i]  = '0;
      pr_last[i]   = '0;
      pr_cursor[i] = 0;
      pr_recs[i]   = 0;
      pr_dist[i]   = '0;
      pr_climb[i]  = '0;
   endfunction

   function automatic logic [31:0] sat32(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // slot counters copied into a response
   function automatic void load_slot(inout rsp_type e, input int unsigned s);
      e.slot           = s[2:0];
      e.stream_len     = pr_cursor[s][21:0];
      e.record_count   = pr_recs[s][21:0];
      e.ride_begin     = pr_start[s];
      e.last_time      = pr_last[s];
      e.distance_total = pr_dist[s];
      e.climb_total    = pr_climb[s];
   endfunction

   // works out the response of one request and updates the table
   function automatic bit slot_table_step(input req_type r, output rsp_type e);
      int unsigned i, s, len, cur, aligned;
      logic [63:0] addr;
      e = '0;
      case (r.opcode)
         OP_START: begin
            if (pr_live) begin
               e.status = ST_ACTIVE;
               e.slot = pr_live_idx[2:0];
               return 1;
            end
            for (int n = 0; n < SLOTS; n++) begin
               i = (pr_hint + n) % SLOTS;
               if (pr_phase[i] == PH_FREE) begin
                  wipe_slot(i);
                  pr_phase[i] = PH_REC;
                  pr_start[i] = r.timestamp;
                  pr_last[i] = r.timestamp;
                  pr_hint = (i + 1) % SLOTS;
                  pr_live = 1;
                  pr_live_idx = i;
                  e.status = ST_OK;
                  load_slot(e, i);
                  return 1;
               end
            end
            e.status = ST_NO_FREE;
         end
         OP_APPEND: begin
            if (!pr_live) begin
               e.status = ST_NOT_ACTIVE;
               return 1;
            end
            s = pr_live_idx % SLOTS;
            len = reg_rec + ((pr_recs[s] == 0) ? reg_extra : 0);
            cur = pr_cursor[s];
            if ((cur % SECTSZ) + len > SECTSZ) cur = (cur / SECTSZ + 1) * SECTSZ;
            if (cur + len > SLOTSZ) begin
               pr_phase[s] = PH_PEND;
               pr_live = 0;
               e.status = ST_FULL;
               load_slot(e, s);
               return 1;
            end
            aligned = cur & ~32'd3;
            addr = 64'(reg_base) + 64'(s) * 64'(SLOTSZ) + 64'(aligned);
            e.erase_first = (cur % SECTSZ) == 0;
            e.flash_addr  = addr[25:0];
            e.pad_count   = 2'(cur - aligned);
            e.write_len   = 10'(((cur - aligned) + len + 3) & ~32'd3);
            pr_cursor[s] = cur + len;
            if (pr_recs[s] < REC_MAX) pr_recs[s]++;
            pr_last[s]  = r.timestamp;
            pr_dist[s]  = sat32(pr_dist[s], r.distance_delta);
            pr_climb[s] = sat32(pr_climb[s], r.ascent_delta);
            e.status = ST_OK;
            load_slot(e, s);
         end
         OP_STOP: begin
            if (!pr_live) begin
               e.status = ST_NOT_ACTIVE;
               return 1;
            end
            s = pr_live_idx % SLOTS;
            pr_phase[s] = PH_PEND;
            pr_live = 0;
            e.status = ST_OK;
            load_slot(e, s);
         end
         OP_EXPORT: begin
            if (r.slot_id >= SLOTS || pr_phase[r.slot_id] != PH_PEND) begin
               e.status = ST_NOT_PEND;
               e.slot = r.slot_id;
               return 1;
            end
            if (r.export_ok) wipe_slot(r.slot_id);
            e.status = ST_OK;
            load_slot(e, r.slot_id);
         end
         OP_TOTALS: begin
            if (pr_live) begin
               load_slot(e, pr_live_idx % SLOTS);
               return 1;
            end
            for (int n = 0; n < SLOTS; n++)
               if (pr_recs[n] > 0) begin
                  load_slot(e, n);
                  return 1;
               end
            e.status = ST_NO_TOTALS;
         end
         default: return 0;
      endcase
      return 1;
   endfunction

   // ---------------- response checking ----------------
   function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1;
      if (fail_count < 10)
         $display("mismatch %s: expected %h actual %h", name, want, got);
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type w, a;
      bit ok;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (expected_rsps.size() == 0) begin
            if (fail_count < 10) $display("response with nothing expected: %p", a);
            fail_count++;
         end else begin
            w = expected_rsps.pop_front();
            ok = 1;
            ok &= field_ok("status", w.status, a.status);
            ok &= field_ok("slot", w.slot, a.slot);
            ok &= field_ok("erase_first", w.erase_first, a.erase_first);
            ok &= field_ok("flash_addr", w.flash_addr, a.flash_addr);
            ok &= field_ok("pad_count", w.pad_count, a.pad_count);
            ok &= field_ok("write_len", w.write_len, a.write_len);
            ok &= field_ok("stream_len", w.stream_len, a.stream_len);
            ok &= field_ok("record_count", w.record_count, a.record_count);
            ok &= field_ok("ride_begin", w.ride_begin, a.ride_begin);
            ok &= field_ok("last_time", w.last_time, a.last_time);
            ok &= field_ok("distance_total", w.distance_total, a.distance_total);
            ok &= field_ok("climb_total", w.climb_total, a.climb_total);
            if (!ok) fail_count++;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------- drivers ----------------
   // offers one request, with random idle cycles ahead of it
   task automatic send_request(input req_type r, input bit typed, input rsp_type tv);
      rsp_type e;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (slot_table_step(r, e)) expected_rsps.push_back(typed ? tv : e);
   endtask

   // waits for every response, then long enough for an ignored request
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{index: idx, data: val};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_BASE:   reg_base  = val[25:0];
         CSR_EXTRA:  reg_extra = val[7:0];
         CSR_RECORD: reg_rec   = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [25:0] b, input logic [7:0] x, input logic [7:0] rb);
      drain();
      csr_write(CSR_BASE, {6'd0, b});
      csr_write(CSR_EXTRA, {24'd0, x});
      csr_write(CSR_RECORD, {24'd0, rb});
   endtask

   function automatic req_type mk(logic [2:0] op, logic [31:0] ts = 0,
                                  logic [15:0] dd = 0, logic [15:0] cd = 0,
                                  logic [2:0] id = 0, logic ok = 0);
      req_type r;
      r.opcode = op;
      r.timestamp = ts;
      r.distance_delta = dd;
      r.ascent_delta = cd;
      r.slot_id = id;
      r.export_ok = ok;
      return r;
   endfunction

   // mostly well-formed ride traffic, with some noise
   function automatic req_type random_request();
      int unsigned p;
      req_type r;
      r = mk(OP_APPEND, $urandom(), 16'($urandom()), 16'($urandom()),
             3'($urandom_range(4)), 1'($urandom_range(1)));
      p = $urandom_range(99);
      if (p < 8) r.opcode = OP_START;
      else if (p < 72) r.opcode = OP_APPEND;
      else if (p < 80) r.opcode = OP_STOP;
      else if (p < 90) begin
         r.opcode = OP_EXPORT;
         if ($urandom_range(9) == 0) r.slot_id = 3'($urandom_range(7));
      end else if (p < 95) r.opcode = OP_TOTALS;
      else r.opcode = 3'($urandom_range(7));
      if ($urandom_range(19) == 0) r.distance_delta = 16'hFFFF;
      if ($urandom_range(19) == 0) r.ascent_delta = 16'hFFFF;
      return r;
   endfunction

   // ---------------- directed table ----------------
   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } row_type;

   row_type rows[$];

   function automatic void add_row(req_type r, bit typed = 0, rsp_type e = '0);
      rows.push_back('{r: r, typed: typed, e: e});
   endfunction

   function automatic rsp_type err_rsp(status_type st, logic [2:0] sl = 0);
      rsp_type e;
      e = '0;
      e.status = st;
      e.slot = sl;
      return e;
   endfunction

   task automatic build_rows();
      rsp_type e;
      // nothing recorded yet: every query fails
      add_row(mk(OP_TOTALS), 1, err_rsp(ST_NO_TOTALS));
      add_row(mk(OP_APPEND, 32'h1234, 16'h10, 16'h20), 1, err_rsp(ST_NOT_ACTIVE));
      add_row(mk(OP_STOP), 1, err_rsp(ST_NOT_ACTIVE));
      add_row(mk(OP_EXPORT, 0, 0, 0, 3'd7, 1), 1, err_rsp(ST_NOT_PEND, 3'd7));
      add_row(mk(OP_EXPORT, 0, 0, 0, 3'd0, 1), 1, err_rsp(ST_NOT_PEND, 3'd0));
      // start at the largest timestamp lands in slot 0
      e = '0;
      e.ride_begin = 32'hFFFF_FFFF;
      e.last_time = 32'hFFFF_FFFF;
      add_row(mk(OP_START, 32'hFFFF_FFFF), 1, e);
      add_row(mk(OP_START, 32'h5), 1, err_rsp(ST_ACTIVE, 3'd0));
      add_row(mk(OP_APPEND, 32'h0, 16'hFFFF, 16'hFFFF));
      add_row(mk(OP_APPEND, 32'hFFFF_FFFF, 16'h0, 16'h0));
      // unknown opcodes give no response
      add_row(mk(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1));
      add_row(mk(3'd7));
      add_row(mk(OP_TOTALS));
      add_row(mk(OP_STOP));
      add_row(mk(OP_TOTALS));
      add_row(mk(OP_EXPORT, 0, 0, 0, 3'd0, 0));
      add_row(mk(OP_EXPORT, 0, 0, 0, 3'd0, 1));
      // fill every slot round-robin, then ask for one more
      for (int k = 0; k < SLOTS; k++) begin
         add_row(mk(OP_START, 32'(k * 100)));
         add_row(mk(OP_STOP));
      end
      add_row(mk(OP_START, 32'h99), 1, err_rsp(ST_NO_FREE));
   endtask

   // ---------------- main sequence ----------------
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      hold_len = 0;
      hold_left = 0;
      fail_count = 0;
      for (int i = 0; i < SLOTS; i++) wipe_slot(i);
      pr_hint = 0;
      pr_live = 0;
      pr_live_idx = 0;
      reg_base = '0;
      reg_extra = '0;
      reg_rec = 8'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      build_rows();
      foreach (rows[k]) send_request(rows[k].r, rows[k].typed, rows[k].e);

      // free all slots, then a long ride in one slot across many sectors
      set_regs(26'h3FF_FFFF, 8'd255, 8'd255);
      for (int k = 0; k < SLOTS; k++) send_request(mk(OP_EXPORT, 0, 0, 0, 3'(k), 1), 0, '0);
      send_request(mk(OP_START, 32'h100), 0, '0);
      for (int k = 0; k < 300; k++)
         send_request(mk(OP_APPEND, $urandom(), 16'($urandom()), 16'($urandom())), 0, '0);
      send_request(mk(OP_TOTALS), 0, '0);

      // random traffic: five idling phases, settings changed between them
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  set_regs('0, 8'd0, 8'd1); end
            1: begin idle_pct = 75; stall_pct = 0;
               set_regs(26'($urandom()), 8'($urandom()), 8'd255); end
            2: begin idle_pct = 0;  stall_pct = 75;
               set_regs(26'h3FF_FFFF, 8'd255, 8'($urandom_range(255, 1))); end
            3: begin idle_pct = 16; stall_pct = 16;
               set_regs(26'($urandom()), 8'($urandom()), 8'($urandom_range(255, 1))); end
            default: begin idle_pct = 16; stall_pct = 16;
               // zero-length records
               set_regs(26'($urandom()), 8'd0, 8'd0); end
         endcase
         for (int k = 0; k < ((ph == 4) ? 100 : 350); k++)
            send_request(random_request(), 0, '0);
         // long receiver hold-off while requests keep coming
         if (ph == 0) begin
            hold_len = 300;
            for (int k = 0; k < 30; k++) send_request(random_request(), 0, '0);
         end
         // sender pauses until every response has come back
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("ride_slot_log_manager_unit verification clean");
      else
         $display("ride_slot_log_manager_unit verification failed");
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("ride_slot_log_manager_unit verification failed");
      $finish;
   end
endmodule
